FILE: src/comb_allpass_reverb_unit_assert.svh
`ifndef COMB_ALLPASS_REVERB_UNIT_ASSERT_SVH
`define COMB_ALLPASS_REVERB_UNIT_ASSERT_SVH
// concurrent assertion helpers
`ifndef NO_ASSERTIONS
`define CAR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define CAR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define CAR_ASSERT(lbl, clk, rstn, prop, msg)
`define CAR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

FILE: src/car_pkg.sv
package car_pkg;
  localparam int unsigned LineDepthDefault = 256;
  localparam int unsigned CombCount = 6;
  localparam int unsigned LineW = 24;
  localparam int unsigned SampleW = 16;
  localparam int unsigned CfgW = 48;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] RegCombDelay = 3'd0;
  localparam logic [CfgIdxW-1:0] RegGainsA = 3'd1;
  localparam logic [CfgIdxW-1:0] RegGainsB = 3'd2;
  localparam logic [CfgIdxW-1:0] RegApDelay = 3'd3;
  localparam logic [CfgIdxW-1:0] RegApGain = 3'd4;
  localparam logic [CfgIdxW-1:0] RegDryMix = 3'd5;
  localparam logic [CfgIdxW-1:0] RegEnable = 3'd6;

  localparam logic [47:0] RstCombDelay = 48'd67298566413589;
  localparam logic [47:0] RstGainsA = 48'd91480011726848;
  localparam logic [47:0] RstGainsB = 48'd70369925287117;
  localparam logic [7:0] RstApDelay = 8'd13;
  localparam logic [14:0] RstApGain = 15'd16384;
  localparam logic [15:0] RstDryMix = 16'd16384;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_COMB_RD, ST_COMB_MUL, ST_COMB_WR, ST_AVG,
    ST_AP_RD, ST_AP_V, ST_AP_Y, ST_MIX, ST_OUT
  } car_state_e;

  typedef struct packed {
    logic load;
    logic clr_wr;
    logic comb_rd;
    logic comb_acc;
    logic avg;
    logic ap_rd;
    logic ap_v;
    logic ap_y;
    logic mix;
    logic bypass;
    logic adv;
    logic [2:0] comb_sel;
  } car_cmd_t;

  typedef struct packed {
    logic clr_done;
  } car_stat_t;

  function automatic logic signed [LineW-1:0] sat24(input logic signed [47:0] v);
    if (v > 48'sd8388607) return 24'sh7FFFFF;
    if (v < -48'sd8388608) return 24'sh800000;
    return v[LineW-1:0];
  endfunction

  function automatic logic signed [47:0] rnd15(input logic signed [47:0] v);
    logic signed [47:0] w;
    w = v + 48'sd16384;
    return w >>> 15;
  endfunction
endpackage

FILE: src/comb_allpass_reverb_unit.sv
// channel | direction | signals
// sample  | in        | sample_in_valid_i, sample_in_ready_o, sample_in_i
// result  | out       | sample_out_valid_o, sample_out_ready_i, sample_out_o
// config  | in        | cfg_we_i, cfg_index_i, cfg_wdata_i
// enabled sample: six comb read/multiply/write rounds, then average, all-pass and mix before the result
// disabled sample: result in the cycle after accept
// after reset a clear pass zeroes the lines; no input taken
// output register holds until taken; a new sample waits for it to drain
module comb_allpass_reverb_unit import car_pkg::*; #(
  parameter int unsigned LineDepth = LineDepthDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      sample_in_valid_i,
  output logic                      sample_in_ready_o,
  input  logic signed [SampleW-1:0] sample_in_i,
  output logic                      sample_out_valid_o,
  input  logic                      sample_out_ready_i,
  output logic signed [SampleW-1:0] sample_out_o,
  input  logic                      cfg_we_i,
  input  logic [CfgIdxW-1:0]        cfg_index_i,
  input  logic [CfgW-1:0]           cfg_wdata_i
);
  logic [CfgW-1:0] cd_q, ga_q, gb_q;
  logic [7:0] apd_q;
  logic [14:0] apg_q;
  logic [15:0] mix_q;
  logic en_q;
  car_cmd_t cmd;
  car_stat_t stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cd_q <= RstCombDelay;
      ga_q <= RstGainsA;
      gb_q <= RstGainsB;
      apd_q <= RstApDelay;
      apg_q <= RstApGain;
      mix_q <= RstDryMix;
      en_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegCombDelay: cd_q <= cfg_wdata_i;
        RegGainsA: ga_q <= cfg_wdata_i;
        RegGainsB: gb_q <= cfg_wdata_i;
        RegApDelay: apd_q <= cfg_wdata_i[7:0];
        RegApGain: apg_q <= cfg_wdata_i[14:0];
        RegDryMix: mix_q <= cfg_wdata_i[15:0];
        RegEnable: en_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  car_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(sample_in_valid_i), .in_ready_o(sample_in_ready_o),
    .out_valid_o(sample_out_valid_o), .out_ready_i(sample_out_ready_i),
    .enable_i(en_q), .stat_i(stat), .cmd_o(cmd)
  );

  car_datapath #(.LineDepth(LineDepth)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat), .sample_i(sample_in_i),
    .comb_delay_i(cd_q), .gains_a_i(ga_q), .gains_b_i(gb_q), .ap_delay_i(apd_q),
    .ap_gain_i(apg_q), .dry_mix_i(mix_q), .sample_o(sample_out_o)
  );
endmodule

FILE: src/car_ram.sv
module car_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

FILE: src/car_ctrl.sv
module car_ctrl import car_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  logic      enable_i,
  input  car_stat_t stat_i,
  output car_cmd_t  cmd_o
);
  car_state_e state_q, state_d;
  logic [2:0] sel_q, sel_d;
  logic ov_q, ov_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      sel_q <= '0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sel_q <= sel_d;
      ov_q <= ov_d;
    end
  end

  always_comb begin
    state_d = state_q;
    sel_d = sel_q;
    ov_d = ov_q;
    cmd_o = '0;
    cmd_o.comb_sel = sel_q;
    in_ready_o = 1'b0;
    if (out_ready_i) ov_d = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.clr_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = !ov_q || out_ready_i;
        if (in_valid_i && in_ready_o) begin
          cmd_o.load = 1'b1;
          sel_d = '0;
          if (enable_i) begin
            state_d = ST_COMB_RD;
          end else begin
            cmd_o.bypass = 1'b1;
            ov_d = 1'b1;
          end
        end
      end
      ST_COMB_RD: state_d = ST_COMB_MUL;
      // read data of the line is registered and valid in the cycle after the address
      ST_COMB_MUL: begin
        cmd_o.comb_rd = 1'b1;
        state_d = ST_COMB_WR;
      end
      ST_COMB_WR: begin
        cmd_o.comb_acc = 1'b1;
        if (sel_q == 3'(CombCount - 1)) begin
          state_d = ST_AVG;
        end else begin
          sel_d = sel_q + 3'd1;
          state_d = ST_COMB_RD;
        end
      end
      ST_AVG: begin
        cmd_o.avg = 1'b1;
        state_d = ST_AP_RD;
      end
      ST_AP_RD: begin
        cmd_o.ap_rd = 1'b1;
        state_d = ST_AP_V;
      end
      ST_AP_V: begin
        cmd_o.ap_v = 1'b1;
        state_d = ST_AP_Y;
      end
      ST_AP_Y: begin
        cmd_o.ap_y = 1'b1;
        state_d = ST_MIX;
      end
      ST_MIX: begin
        cmd_o.mix = 1'b1;
        cmd_o.adv = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!ov_q || out_ready_i) begin
          ov_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = ov_q;
endmodule

FILE: src/car_datapath.sv
module car_datapath import car_pkg::*; #(
  parameter int unsigned LineDepth = LineDepthDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  car_cmd_t                  cmd_i,
  output car_stat_t                 stat_o,
  input  logic signed [SampleW-1:0] sample_i,
  input  logic [CfgW-1:0]           comb_delay_i,
  input  logic [CfgW-1:0]           gains_a_i,
  input  logic [CfgW-1:0]           gains_b_i,
  input  logic [7:0]                ap_delay_i,
  input  logic [14:0]               ap_gain_i,
  input  logic [15:0]               dry_mix_i,
  output logic signed [SampleW-1:0] sample_o
);
  localparam int unsigned AW = $clog2(LineDepth);
  localparam int unsigned CW = $clog2(CombCount * LineDepth);

  logic [AW-1:0] widx_q;
  logic [CW-1:0] clr_q;
  logic clr_done;
  logic signed [SampleW-1:0] x_q, out_q;
  logic signed [LineW+3:0] sum_q;
  logic signed [LineW-1:0] w_q, v_q, y_q, apold_q;
  logic signed [47:0] prod_q;
  logic signed [LineW-1:0] comb_rd, ap_rd, c_val;
  logic signed [16:0] gain;
  logic [AW-1:0] d_comb, d_ap;
  logic [AW-1:0] comb_roff;
  logic [CW-1:0] comb_raddr, comb_waddr;
  logic signed [47:0] recip;

  assign clr_done = (clr_q == CW'(CombCount * LineDepth - 1));
  assign stat_o.clr_done = clr_done;

  always_comb begin
    logic [15:0] g;
    case (cmd_i.comb_sel)
      3'd0: g = gains_a_i[15:0];
      3'd1: g = gains_a_i[31:16];
      3'd2: g = gains_a_i[47:32];
      3'd3: g = gains_b_i[15:0];
      3'd4: g = gains_b_i[31:16];
      default: g = gains_b_i[47:32];
    endcase
    gain = {g[15], g};
  end

  assign d_comb = AW'(comb_delay_i[{cmd_i.comb_sel, 3'b000} +: 8]);
  assign d_ap = AW'(ap_delay_i);
  assign comb_roff = widx_q - d_comb;
  assign comb_raddr = CW'(cmd_i.comb_sel) * CW'(LineDepth) + CW'(comb_roff);
  assign comb_waddr = cmd_i.clr_wr ? clr_q
                    : CW'(cmd_i.comb_sel) * CW'(LineDepth) + CW'(widx_q);
  assign c_val = sat24(48'(x_q) + rnd15(prod_q));

  car_ram #(.Width(LineW), .Depth(CombCount * LineDepth)) u_comb_ram (
    .clk_i, .we_i(cmd_i.clr_wr || cmd_i.comb_acc), .waddr_i(comb_waddr),
    .wdata_i(cmd_i.clr_wr ? '0 : c_val), .raddr_i(comb_raddr), .rdata_o(comb_rd)
  );
  car_ram #(.Width(LineW), .Depth(LineDepth)) u_ap_ram (
    .clk_i, .we_i(cmd_i.clr_wr || cmd_i.ap_y),
    .waddr_i(cmd_i.clr_wr ? clr_q[AW-1:0] : widx_q),
    .wdata_i(cmd_i.clr_wr ? '0 : v_q), .raddr_i(widx_q - d_ap), .rdata_o(ap_rd)
  );

  // division by six, rounded to nearest, for |sum| < 2^27 via multiply by ceil(2^32/6)
  always_comb begin
    logic [LineW+2:0] mag;
    logic [63:0] q;
    mag = sum_q[LineW+3] ? LineW'(0) + 27'(-sum_q + 28'sd3) : 27'(sum_q + 28'sd3);
    q = (64'(mag) * 64'd715827883) >> 32;
    recip = sum_q[LineW+3] ? -48'(q) : 48'(q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      widx_q <= '0;
      clr_q <= '0;
    end else begin
      if (cmd_i.clr_wr && !clr_done) clr_q <= clr_q + CW'(1);
      if (cmd_i.adv) widx_q <= widx_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q <= sample_i;
      sum_q <= '0;
      if (cmd_i.bypass) out_q <= sample_i;
    end
    if (cmd_i.comb_rd) prod_q <= 48'(gain) * 48'(comb_rd);
    if (cmd_i.comb_acc) sum_q <= sum_q + 28'(c_val);
    if (cmd_i.avg) w_q <= LineW'(recip);
    if (cmd_i.ap_rd) apold_q <= ap_rd;
    if (cmd_i.ap_v) v_q <= sat24(48'(w_q) + rnd15(48'(ap_rd) * 48'($signed({1'b0, ap_gain_i}))));
    if (cmd_i.ap_y) y_q <= sat24(48'(apold_q) - rnd15(48'(v_q) * 48'($signed({1'b0, ap_gain_i}))));
    if (cmd_i.mix) begin
      logic [16:0] m;
      logic signed [47:0] mx;
      m = (dry_mix_i > 16'd32768) ? 17'd32768 : 17'(dry_mix_i);
      mx = rnd15(48'(x_q) * 48'($signed({1'b0, m}))
                 + 48'(y_q) * 48'($signed(18'd32768 - 18'(m))));
      if (mx > 48'sd32767) out_q <= 16'sh7FFF;
      else if (mx < -48'sd32768) out_q <= 16'sh8000;
      else out_q <= mx[15:0];
    end
  end

  assign sample_o = out_q;

  `include "comb_allpass_reverb_unit_assert.svh"
  `CAR_ASSERT_NEXT(a_widx_adv, clk_i, rst_ni, cmd_i.adv, widx_q == $past(widx_q) + AW'(1), "index")
  `CAR_ASSERT(a_no_clr_mix, clk_i, rst_ni, !(cmd_i.clr_wr && cmd_i.load), "clear overlap")
  `CAR_ASSERT(a_sel_range, clk_i, rst_ni, cmd_i.comb_sel < 3'(CombCount), "comb select")
endmodule
